/* sv/tcw_pkg.sv */
package tcw_pkg;

    // Default console geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOUR_W  = 4;
    localparam int DELTA_W   = 12;
    localparam int CA_W      = 11;
    localparam int LOC_W     = 11;
    localparam int CELL_W    = 16;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    // Magnitude of the most negative delta
    localparam int DELTA_MAG = 2048;

    // Dividend width of the cursor divider at the default geometry
    localparam int DIVIDEND_W_DEF = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_CHAR  = 2'd0,
        CMD_MOVE_CURSOR = 2'd1,
        CMD_CLEAR       = 2'd2,
        CMD_READ_CELL   = 2'd3
    } tcw_cmd_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_FG   = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam int TAB_STEP = 8;

    localparam logic [CFG_W-1:0]  BG_RESET   = 4'h0;
    localparam logic [CFG_W-1:0]  FG_RESET   = 4'hF;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

endpackage

/* sv/tcw_ram.sv */
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/tcw_div.sv */
module tcw_div
    import tcw_pkg::*;
#(
    parameter int DIVISOR    = COLUMNS_DEF,
    parameter int DIVIDEND_W = DIVIDEND_W_DEF,
    localparam int RMW    = $clog2(DIVISOR),
    localparam int SHIFT  = DIVIDEND_W + RMW,
    localparam int PROD_W = 2 * DIVIDEND_W + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [RMW-1:0]        remainder
);

    // Reciprocal rounded up; exact for every dividend of DIVIDEND_W bits
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                               / longint'(DIVISOR);
    localparam logic [DIVIDEND_W:0] RECIP = (DIVIDEND_W+1)'(RECIP_L);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [RMW-1:0]        rem_reg, rem_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [PROD_W-1:0]     product;
    logic [DIVIDEND_W-1:0] back;

    assign product = PROD_W'(dividend) * PROD_W'(RECIP);
    assign back    = quo_reg * DIVIDEND_W'(DIVISOR);

    // The quotient is registered on start; the remainder follows from the registered quotient, together with done
    always_comb
    begin
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = DIVIDEND_W'(product >> SHIFT);
            dvd_next  = dividend;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = RMW'(dvd_reg - back);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/text_console_writer_unit.sv */
// Channel   | Signals                                          | Direction
// ----------+--------------------------------------------------+----------
// command   | cmd_valid/cmd_ready, command, char_code, colour, | in
//           | delta_col, delta_row, cell_address               |
// response  | rsp_valid/rsp_ready, cursor_location, cell_data  | out
// config    | cfg_write_en, cfg_index, cfg_data                | in
//
// write_char and read_cell go through S_CHAR or S_READ to S_DONE and the response; a scroll adds
// a store copy and last-row blanking (one cell per cycle, blanking held while the last copy writes).
// move_cursor waits in S_DIV for quotient and remainder by reciprocal multiply.
// clear blanks the whole store, one cell written per cycle through the RAM port.
// After reset the store is swept to the blank cell with cmd_ready low; a stalled
// response is held while the next item is accepted.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  logic [CMD_W-1:0]            command,
    input  logic [CHAR_W-1:0]           char_code,
    input  logic [COLOUR_W-1:0]         colour,
    input  logic signed [DELTA_W-1:0]   delta_col,
    input  logic signed [DELTA_W-1:0]   delta_row,
    input  logic [CA_W-1:0]             cell_address,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [LOC_W-1:0]            cursor_location,
    output logic [CELL_W-1:0]           cell_data,
    input  logic                        cfg_write_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data
);

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int CW      = $clog2(COLUMNS);
    localparam int RW      = $clog2(ROWS);
    localparam int AW      = $clog2(CELLS);
    localparam int CMP_W   = ((AW > CA_W) ? AW : CA_W) + 1;
    localparam int BIAS_Q  = (DELTA_MAG + COLUMNS - 1) / COLUMNS;
    localparam int BIAS    = BIAS_Q * COLUMNS;
    localparam int DIV_MAX = (COLUMNS - 1) + (DELTA_MAG - 1) + BIAS;
    localparam int DW      = $clog2(DIV_MAX + 1);
    localparam int YW      = DW + 2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHAR,
        S_DIV,
        S_SCROLL,
        S_BLANK,
        S_READ,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [RW-1:0]             row_reg, row_next;
    logic [CFG_W-1:0]          bg_reg, bg_next;
    logic [CFG_W-1:0]          fg_reg, fg_next;
    logic [AW-1:0]             ptr_reg, ptr_next;
    logic [AW-1:0]             dst_reg, dst_next;
    logic                      copy_valid_reg, copy_valid_next;
    logic [CHAR_W-1:0]         char_reg, char_next;
    logic [COLOUR_W-1:0]       colour_reg, colour_next;
    logic signed [DELTA_W-1:0] dr_reg, dr_next;
    logic                      addr_ok_reg, addr_ok_next;
    logic [CELL_W-1:0]         res_data_reg, res_data_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    logic [LOC_W-1:0]          rsp_loc_reg, rsp_loc_next;
    logic [CELL_W-1:0]         rsp_data_reg, rsp_data_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [CELL_W-1:0]         ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [CELL_W-1:0]         ram_rdata;

    logic                      div_start;
    logic [DW-1:0]             div_dividend;
    logic                      div_done;
    logic [DW-1:0]             div_quo;
    logic [CW-1:0]             div_rem;

    logic [AW-1:0]             cur_addr;
    logic [CELL_W-1:0]         blank_cell;
    logic                      char_printable;
    logic [CW:0]               col_ext;
    logic [CW:0]               char_col_adv;
    logic                      char_row_inc;
    logic [RW:0]               char_row_adv;
    logic signed [YW-1:0]      move_y;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_div #(
        .DIVISOR    (COLUMNS),
        .DIVIDEND_W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign cur_addr       = AW'(row_reg * COLUMNS + col_reg);
    assign blank_cell     = {bg_reg, fg_reg, CH_SPACE};
    assign char_printable = !char_reg[CHAR_W-1] && (char_reg[6:5] != 2'b00);
    assign col_ext        = {1'b0, col_reg};

    // Bias the column sum by a whole number of rows so the division stays unsigned
    assign div_dividend = DW'(col_reg) + DW'(delta_col) + DW'(BIAS);
    assign move_y = $signed(YW'(row_reg)) + YW'(dr_reg) + $signed(YW'(div_quo))
                  - $signed(YW'(BIAS_Q));

    always_comb
    begin
        char_row_inc = 1'b0;
        case (char_reg)
            CH_BS:   char_col_adv = (col_reg != '0) ? col_ext - 1'b1 : col_ext;
            CH_TAB:  char_col_adv = (col_ext + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
            CH_CR:   char_col_adv = '0;
            CH_LF:
            begin
                char_col_adv = '0;
                char_row_inc = 1'b1;
            end
            default: char_col_adv = char_printable ? col_ext + 1'b1 : col_ext;
        endcase
        // Wrap to the start of the next line
        if (char_col_adv >= (CW+1)'(COLUMNS))
        begin
            char_col_adv = '0;
            char_row_inc = 1'b1;
        end
        char_row_adv = {1'b0, row_reg} + (RW+1)'(char_row_inc);
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        bg_next         = bg_reg;
        fg_next         = fg_reg;
        ptr_next        = ptr_reg;
        dst_next        = dst_reg;
        copy_valid_next = 1'b0;
        char_next       = char_reg;
        colour_next     = colour_reg;
        dr_next         = dr_reg;
        addr_ok_next    = addr_ok_reg;
        res_data_next   = res_data_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_loc_next    = rsp_loc_reg;
        rsp_data_next   = rsp_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = blank_cell;
        ram_raddr       = ptr_reg;
        div_start       = 1'b0;

        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_BACKGROUND: bg_next = cfg_data;
                REG_CLEAR_FG:   fg_next = cfg_data;
                default:        bg_next = bg_reg;
            endcase
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = RESET_CELL;
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                ram_raddr = AW'(cell_address);
                if (cmd_valid)
                begin
                    char_next     = char_code;
                    colour_next   = colour;
                    dr_next       = delta_row;
                    res_data_next = '0;
                    addr_ok_next  = CMP_W'(cell_address) < CMP_W'(CELLS);
                    case (tcw_cmd_t'(command))
                        CMD_WRITE_CHAR:  state_next = S_CHAR;
                        CMD_MOVE_CURSOR:
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                        CMD_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            ptr_next   = '0;
                            state_next = S_BLANK;
                        end
                        CMD_READ_CELL:   state_next = S_READ;
                        default:         state_next = S_DONE;
                    endcase
                end
            end
            S_CHAR:
            begin
                ram_we    = char_printable;
                ram_waddr = cur_addr;
                ram_wdata = {bg_reg, colour_reg, char_reg};
                col_next  = char_col_adv[CW-1:0];
                if (char_row_adv >= (RW+1)'(ROWS))
                begin
                    row_next   = RW'(ROWS - 1);
                    ptr_next   = AW'(COLUMNS);
                    state_next = S_SCROLL;
                end
                else
                begin
                    row_next   = char_row_adv[RW-1:0];
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (move_y < 0)
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    else if (move_y >= $signed(YW'(ROWS)))
                    begin
                        col_next = CW'(COLUMNS - 1);
                        row_next = RW'(ROWS - 1);
                    end
                    else
                    begin
                        col_next = div_rem;
                        row_next = move_y[RW-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_SCROLL:
            begin
                // Read one row ahead; the copy is written in the following cycle
                copy_valid_next = 1'b1;
                dst_next        = ptr_reg - AW'(COLUMNS);
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    ptr_next   = AW'(CELLS - COLUMNS);
                    state_next = S_BLANK;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_BLANK:
            begin
                // Hold while the last copy owns the write port
                if (!copy_valid_reg)
                begin
                    ram_we = 1'b1;
                    if (ptr_reg == AW'(CELLS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (addr_ok_reg)
                begin
                    res_data_next = ram_rdata;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_loc_next   = LOC_W'(cur_addr);
                    rsp_data_next  = res_data_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (copy_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = dst_reg;
            ram_wdata = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            bg_reg         <= BG_RESET;
            fg_reg         <= FG_RESET;
            ptr_reg        <= '0;
            dst_reg        <= '0;
            copy_valid_reg <= 1'b0;
            char_reg       <= '0;
            colour_reg     <= '0;
            dr_reg         <= '0;
            addr_ok_reg    <= 1'b0;
            res_data_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_loc_reg    <= '0;
            rsp_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            bg_reg         <= bg_next;
            fg_reg         <= fg_next;
            ptr_reg        <= ptr_next;
            dst_reg        <= dst_next;
            copy_valid_reg <= copy_valid_next;
            char_reg       <= char_next;
            colour_reg     <= colour_next;
            dr_reg         <= dr_next;
            addr_ok_reg    <= addr_ok_next;
            res_data_reg   <= res_data_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_loc_reg    <= rsp_loc_next;
            rsp_data_reg   <= rsp_data_next;
        end
    end

    assign cmd_ready       = (state_reg == S_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign cursor_location = rsp_loc_reg;
    assign cell_data       = rsp_data_reg;

endmodule

/* sv/tcw_checker.sv */
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [LOC_W-1:0]  cursor_location,
    input logic [CELL_W-1:0] cell_data
);

    localparam int CELLS = COLUMNS * ROWS;

    logic       cmd_fire;
    logic       rsp_fire;
    logic [1:0] outstanding_reg, outstanding_next;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        case ({cmd_fire, rsp_fire})
            2'b10:   outstanding_next = outstanding_reg + 1'b1;
            2'b01:   outstanding_next = outstanding_reg - 1'b1;
            default: outstanding_next = outstanding_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A stalled response holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cursor_location)
                                    && $stable(cell_data))
        else $error("response changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(cursor_location) < CELLS || CELLS > (1 << LOC_W))
        else $error("cursor location outside the screen");

    // cmd_ready drops in the cycle after every accepted command
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !cmd_ready)
        else $error("command accepted on consecutive cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 2'd0)
        else $error("response with no command outstanding");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |-> outstanding_reg < 2'd2)
        else $error("more than two items in flight");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .cursor_location (cursor_location),
    .cell_data       (cell_data)
);
